FILE: rtl/common_subsequence_length_assert.svh
// ----------------------------------------------------------------------------
// common subsequence length assertion macros
// shared property wrappers for the checker of the block
// ----------------------------------------------------------------------------
`ifndef COMMON_SUBSEQUENCE_LENGTH_ASSERT_SVH
`define COMMON_SUBSEQUENCE_LENGTH_ASSERT_SVH

// general property, sampled on clk, off during reset
`define CSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled beat keeps valid high and its payload steady
`define CSL_ASSERT_HOLD(lbl, vld, stl, data, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl) |=> (vld) && $stable(data))) else $error(msg);

`endif

FILE: rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// types and sizes shared by the common subsequence length block
// ----------------------------------------------------------------------------
package csl_pkg;

    // longest string kept, one cell per symbol
    localparam int MAX_LEN = 1024;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W   = 8;
    localparam int SCORE_W = 11;

    // input beat
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             to_second;
        logic             last;
    } item_t;

    // output beat
    typedef struct packed {
        logic [SCORE_W-1:0] lcs_length;
        logic               overflow;
    } result_t;

    // second-string token moving down the cell row
    typedef struct packed {
        logic               valid;
        logic               upd;
        logic               first;
        logic               last;
        logic [SYM_W-1:0]   symbol;
        logic [SCORE_W-1:0] left;
        logic [SCORE_W-1:0] diag;
    } token_t;

endpackage

FILE: rtl/common_subsequence_length.sv
// ----------------------------------------------------------------------------
// common_subsequence_length
// longest common subsequence length of two byte strings on a row of cells
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid, item_stall, item): first-string beats
//   (to_second = 0) are written into the cell row, one per cycle while
//   item_stall is low. second string beats (to_second = 1) then enter the
//   row one per cycle while not stalled; each moves one cell per cycle
//   and updates that cell's score as it passes. result channel
//   (result_valid, result_stall, result): one beat after the second
//   string's last symbol, with the length and the overflow flag. the last
//   second-string beat reaches the result through the injection register,
//   every cell of the row and the result register.
//   throughput: one beat per cycle within a string unless stalled; after
//   the last beat the item channel stalls until the token leaves the row.
//   a waiting result stalls second-string beats only; first-string beats
//   of the next pair keep loading. result holds while result_stall is high.
//   reset empties the row, clears lengths and flags and drops any result.
// ----------------------------------------------------------------------------
module common_subsequence_length (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  csl_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_stall,
    output csl_pkg::result_t   result
);

    logic [csl_pkg::LEN_W-1:0] first_len_reg;
    logic [csl_pkg::LEN_W-1:0] first_len_next;
    logic [csl_pkg::LEN_W-1:0] second_len_reg;
    logic [csl_pkg::LEN_W-1:0] second_len_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      res_ovf_reg;
    logic                      res_ovf_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    csl_pkg::result_t          result_reg;
    csl_pkg::result_t          result_next;
    csl_pkg::token_t           inj_reg;
    csl_pkg::token_t           inj_next;
    csl_pkg::token_t           chain [csl_pkg::MAX_LEN+1];
    logic                      accept;
    logic                      load_fire;
    logic                      exit_fire;
    logic [csl_pkg::MAX_LEN-1:0] wr_en;

    assign accept     = item_valid && !item_stall;
    assign item_stall = busy_reg || (result_valid_reg && item.to_second);
    assign load_fire  = accept && !item.to_second && (second_len_reg == '0)
                        && (first_len_reg < csl_pkg::LEN_W'(csl_pkg::MAX_LEN));
    assign exit_fire  = chain[csl_pkg::MAX_LEN].valid && chain[csl_pkg::MAX_LEN].last;

    // beat intake, length counting and token injection
    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        res_ovf_next    = res_ovf_reg;
        busy_next       = busy_reg;
        inj_next        = '0;
        inj_next.symbol = item.symbol;
        inj_next.first  = (second_len_reg == '0);
        inj_next.last   = item.last;
        if (accept && !item.to_second)
        begin
            if (second_len_reg == '0)
            begin
                if (first_len_reg < csl_pkg::LEN_W'(csl_pkg::MAX_LEN))
                begin
                    first_len_next = first_len_reg + csl_pkg::LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        else if (accept)
        begin
            if (second_len_reg < csl_pkg::LEN_W'(csl_pkg::MAX_LEN))
            begin
                second_len_next = second_len_reg + csl_pkg::LEN_W'(1);
                inj_next.valid  = 1'b1;
                inj_next.upd    = 1'b1;
            end
            else
            begin
                ovf_next       = 1'b1;
                inj_next.valid = item.last;
            end
            // last beat: start a new pair, hold input until the row drains
            if (item.last)
            begin
                res_ovf_next    = ovf_next;
                first_len_next  = '0;
                second_len_next = '0;
                ovf_next        = 1'b0;
                busy_next       = 1'b1;
            end
        end
        if (exit_fire)
        begin
            busy_next = 1'b0;
        end
    end

    // result register
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (exit_fire)
        begin
            result_valid_next      = 1'b1;
            result_next.lcs_length = chain[csl_pkg::MAX_LEN].left;
            result_next.overflow   = res_ovf_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            ovf_reg          <= 1'b0;
            res_ovf_reg      <= 1'b0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            inj_reg          <= '0;
        end
        else
        begin
            first_len_reg    <= first_len_next;
            second_len_reg   <= second_len_next;
            ovf_reg          <= ovf_next;
            res_ovf_reg      <= res_ovf_next;
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
            inj_reg          <= inj_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign chain[0] = inj_reg;

    // row of cells, written by index while the first string loads
    for (genvar g = 0; g < csl_pkg::MAX_LEN; g++)
    begin : g_cell
        assign wr_en[g] = load_fire
                          && (first_len_reg[csl_pkg::IDX_W-1:0] == csl_pkg::IDX_W'(g));
        csl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en[g]),
            .wr_symbol (item.symbol),
            .clear     (exit_fire),
            .tok       (chain[g]),
            .tok_out   (chain[g+1])
        );
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/csl_cell.sv
// ----------------------------------------------------------------------------
// csl_cell
// one cell of the score row: holds one first-string symbol and its score
// ----------------------------------------------------------------------------
module csl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [csl_pkg::SYM_W-1:0]   wr_symbol,
    input  logic                        clear,
    input  csl_pkg::token_t             tok,
    output csl_pkg::token_t             tok_out
);

    logic [csl_pkg::SYM_W-1:0]   sym_reg;
    logic [csl_pkg::SYM_W-1:0]   sym_next;
    logic                        act_reg;
    logic                        act_next;
    logic [csl_pkg::SCORE_W-1:0] score_reg;
    logic [csl_pkg::SCORE_W-1:0] score_next;
    csl_pkg::token_t             tok_reg;
    csl_pkg::token_t             tok_next;
    logic [csl_pkg::SCORE_W-1:0] up;
    logic [csl_pkg::SCORE_W-1:0] v;

    // score update for the token passing through
    always_comb
    begin
        up = tok.first ? '0 : score_reg;
        if (sym_reg == tok.symbol)
        begin
            v = tok.diag + csl_pkg::SCORE_W'(1);
        end
        else
        begin
            v = (tok.left > up) ? tok.left : up;
        end
        score_next = score_reg;
        tok_next   = tok;
        if (tok.valid && act_reg)
        begin
            if (tok.upd)
            begin
                score_next    = v;
                tok_next.left = v;
                tok_next.diag = up;
            end
            else
            begin
                score_next    = up;
                tok_next.left = up;
                tok_next.diag = up;
            end
        end
    end

    // symbol load and occupancy
    always_comb
    begin
        sym_next = wr_en ? wr_symbol : sym_reg;
        if (clear)
        begin
            act_next = 1'b0;
        end
        else if (wr_en)
        begin
            act_next = 1'b1;
        end
        else
        begin
            act_next = act_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            tok_reg <= tok_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        score_reg <= score_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/csl_checker.sv
// ----------------------------------------------------------------------------
// csl_checker
// port-level checks of the common subsequence length block
// ----------------------------------------------------------------------------
`include "common_subsequence_length_assert.svh"

module csl_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input csl_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input csl_pkg::result_t result
);

    // a waiting result beat keeps its payload
    `CSL_ASSERT_HOLD(a_result_hold, result_valid, result_stall, result, "result changed under stall")

    // no second-string beat enters while a result waits
    `CSL_ASSERT(a_no_second_on_full, result_valid && item.to_second |-> item_stall, "second string taken while result waits")

    // the last second-string beat closes the input until the row drains
    `CSL_ASSERT(a_stall_after_last, item_valid && !item_stall && item.to_second && item.last |=> item_stall, "input open after last beat")

    // a length never exceeds the row size
    `CSL_ASSERT(a_length_range, result_valid |-> result.lcs_length <= csl_pkg::SCORE_W'(csl_pkg::MAX_LEN), "length out of range")

endmodule

bind common_subsequence_length csl_checker u_csl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: sim/common_subsequence_length_tb.sv
// ----------------------------------------------------------------------------
// common_subsequence_length_tb
// drives string pairs into the common subsequence length block and checks
// every result beat against a software dynamic-programming row kept here;
// covers empty, identical, disjoint, full-size and truncated strings plus
// random pairs, with random idle cycles on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module common_subsequence_length_tb;

    // no-accept cycles tolerated, enough for one pair to drain the whole row
    localparam int WATCHDOG_LIMIT = 16 * (csl_pkg::MAX_LEN + 64);
    localparam int ITEM_TARGET    = 1700;

    // predicted lengths, one row of scores over the stored first string
    class lcs_predictor;
        logic [csl_pkg::SYM_W-1:0] first_str [csl_pkg::MAX_LEN];
        int unsigned               row_score [csl_pkg::MAX_LEN];
        int unsigned               first_len;
        int unsigned               second_len;
        bit                        truncated;
        csl_pkg::result_t          expected_lengths [$];
        int                        failures;

        function void flag(string what);
            failures++;
            if (failures <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // update state with one accepted input beat
        function void note_item(csl_pkg::item_t beat);
            int unsigned      diag;
            int unsigned      left;
            int unsigned      up;
            int unsigned      score;
            csl_pkg::result_t want;
            if (!beat.to_second)
            begin
                // first-string symbols are ignored once the second string runs
                if (second_len != 0)
                    return;
                if (first_len < csl_pkg::MAX_LEN)
                begin
                    first_str[first_len] = beat.symbol;
                    first_len++;
                end
                else
                    truncated = 1'b1;
                return;
            end
            if (second_len == 0)
                foreach (row_score[i])
                    row_score[i] = 0;
            if (second_len < csl_pkg::MAX_LEN)
            begin
                second_len++;
                diag = 0;
                left = 0;
                for (int i = 0; i < first_len; i++)
                begin
                    up = row_score[i];
                    if (first_str[i] == beat.symbol)
                        score = diag + 1;
                    else
                        score = (left > up) ? left : up;
                    diag = up;
                    row_score[i] = score;
                    left = score;
                end
            end
            else
                truncated = 1'b1;
            if (!beat.last)
                return;
            want.lcs_length = (first_len == 0) ? '0
                              : csl_pkg::SCORE_W'(row_score[first_len - 1]);
            want.overflow   = truncated;
            expected_lengths = {expected_lengths, want};
            first_len  = 0;
            second_len = 0;
            truncated  = 1'b0;
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(csl_pkg::result_t got);
            csl_pkg::result_t want;
            if (expected_lengths.size() == 0)
            begin
                flag($sformatf("unexpected result beat length %0d overflow %0b",
                               got.lcs_length, got.overflow));
                return;
            end
            want = expected_lengths.pop_front();
            if (got.lcs_length !== want.lcs_length)
                flag($sformatf("lcs_length expected %0d actual %0d",
                               want.lcs_length, got.lcs_length));
            if (got.overflow !== want.overflow)
                flag($sformatf("overflow expected %0b actual %0b",
                               want.overflow, got.overflow));
        endfunction

        // predictions never answered
        function void close_out();
            csl_pkg::result_t lost;
            while (expected_lengths.size() != 0)
            begin
                lost = expected_lengths.pop_front();
                flag($sformatf("missing result beat length %0d", lost.lcs_length));
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    csl_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    csl_pkg::result_t result;

    lcs_predictor              predictor;
    int                        idle_cycles;
    int                        items_sent;
    bit                        source_calm;
    bit                        sink_calm;
    logic [csl_pkg::SYM_W-1:0] alphabet [4];

    common_subsequence_length dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    // idle cycles before the next beat, with occasional runs of none
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [csl_pkg::SYM_W-1:0] pick_symbol(bit any_byte);
        return any_byte ? csl_pkg::SYM_W'($urandom_range(0, 255))
                        : alphabet[$urandom_range(0, 3)];
    endfunction

    // one input beat: optional gap, then hold until accepted
    task automatic send_symbol(input logic [csl_pkg::SYM_W-1:0] sym, input logic second,
                               input logic last_flag);
        int             gap;
        csl_pkg::item_t beat;
        beat.symbol    = sym;
        beat.to_second = second;
        beat.last      = last_flag;
        gap = draw_gap(source_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predictor.note_item(beat);
        items_sent++;
    endtask

    // one string pair with random content, stray last flags on the first
    // string and now and then an ignored first-string beat inside the second
    task automatic run_pair(input int first_n, input int second_n);
        bit any_byte;
        any_byte = ($urandom_range(0, 2) == 0);
        foreach (alphabet[k])
            alphabet[k] = csl_pkg::SYM_W'($urandom_range(0, 255));
        for (int k = 0; k < first_n; k++)
            send_symbol(pick_symbol(any_byte), 1'b0, $urandom_range(0, 3) == 0);
        for (int k = 0; k < second_n; k++)
        begin
            if (k > 0 && $urandom_range(0, 15) == 0)
                send_symbol(pick_symbol(any_byte), 1'b0, 1'($urandom_range(0, 1)));
            send_symbol(pick_symbol(any_byte), 1'b1, k == second_n - 1);
        end
    endtask

    // result side: random stall before each beat
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(sink_calm);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // result check and watchdog on accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                predictor.check_result(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int pair_no;
        int first_n;
        int second_n;
        predictor    = new();
        idle_cycles  = 0;
        items_sent   = 0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        result_stall <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty first string gives zero
        send_symbol(8'h41, 1'b1, 1'b1);
        // byte extremes, last flag on first string, ignored first beat
        send_symbol(8'h00, 1'b0, 1'b1);
        send_symbol(8'hFF, 1'b0, 1'b0);
        send_symbol(8'h5A, 1'b0, 1'b1);
        send_symbol(8'hFF, 1'b1, 1'b0);
        send_symbol(8'h00, 1'b0, 1'b0);
        send_symbol(8'h5A, 1'b1, 1'b1);
        // identical strings
        send_symbol(8'h80, 1'b0, 1'b0);
        send_symbol(8'h7F, 1'b0, 1'b0);
        send_symbol(8'h01, 1'b0, 1'b0);
        send_symbol(8'h80, 1'b1, 1'b0);
        send_symbol(8'h7F, 1'b1, 1'b0);
        send_symbol(8'h01, 1'b1, 1'b1);
        // nothing in common
        send_symbol(8'hAA, 1'b0, 1'b0);
        send_symbol(8'h55, 1'b1, 1'b0);
        send_symbol(8'h55, 1'b1, 1'b1);
        // single matching symbol each
        send_symbol(8'hC3, 1'b0, 1'b0);
        send_symbol(8'hC3, 1'b1, 1'b1);

        // random pairs, one of them past full size on either string
        pair_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pair_no++;
            if (pair_no == 12)
            begin
                if ($urandom_range(0, 1) == 0)
                    run_pair(csl_pkg::MAX_LEN + $urandom_range(1, 4), $urandom_range(1, 8));
                else
                    run_pair($urandom_range(1, 8), csl_pkg::MAX_LEN + $urandom_range(1, 4));
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       first_n = 0;
                    1:       first_n = $urandom_range(17, 64);
                    default: first_n = $urandom_range(1, 16);
                endcase
                second_n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                        : $urandom_range(1, 16);
                run_pair(first_n, second_n);
            end
        end
        item_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (predictor.expected_lengths.size() != 0)
            @(posedge clk);
        repeat (csl_pkg::MAX_LEN + 16) @(posedge clk);
        predictor.close_out();
        if (predictor.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
